FILE: hdl/rotated_array_lower_bound_search_macros.svh
// Assertion helpers, clocked on clk_i and disabled during reset.
`ifndef ROTATED_ARRAY_LOWER_BOUND_SEARCH_MACROS_SVH
`define ROTATED_ARRAY_LOWER_BOUND_SEARCH_MACROS_SVH

`define RALS_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

`define RALS_ASSERT_NEVER(label, cond, msg) \
  `RALS_ASSERT(label, !(cond), msg)

`endif

FILE: hdl/rals_pkg.sv
`default_nettype none

package rals_pkg;

  localparam int unsigned CFG_W           = 11;
  localparam int unsigned DATA_W          = 64;
  localparam int unsigned MAX_ENTRIES_DEF = 1024;

  localparam logic CFG_ENTRY_COUNT  = 1'b0;
  localparam logic CFG_ROTATE_COUNT = 1'b1;

  typedef enum logic {
    REQ_LOAD  = 1'b0,
    REQ_QUERY = 1'b1
  } req_e;

  typedef struct packed {
    logic                     is_query;
    logic [CFG_W-1:0]         addr;
    logic signed [DATA_W-1:0] value;
    logic [CFG_W-1:0]         split;
    logic [CFG_W-1:0]         cnt;
  } rals_cmd_t;

  typedef struct packed {
    logic empty;
    logic full;
  } rals_fifo_stat_t;

endpackage

`default_nettype wire

FILE: hdl/rotated_array_lower_bound_search.sv
// Lower-bound search over a rotated array of signed 64-bit words.
// Input channel (in_valid_i / in_stall_o): a word is a load (req_type_i = 0)
// or a query (req_type_i = 1). Loads fill positions in order, rotated by
// rotate_count; loads past entry_count are dropped. A query yields one word
// on the output channel (out_valid_o / out_stall_i): found_o and the 1-based
// position_o. Loads yield nothing.
// Config: cfg_we_i writes entry_count (index 0) or rotate_count (index 1).
// The user must write only while the block is idle; no logic enforces it.
// A load passes the queue and is written to the element memory once the
// engine is idle. A query makes at most P = ceil(log2(larger segment + 1))
// probes; both segments are bisected in parallel on the two read ports of
// the element memory, each probe an address step, then registered read
// data and compare.
// A two-word queue parts the front from the search engine, so the input
// takes up to two more words while a result waits under out_stall_i; the
// engine holds a finished query until the output register frees up.
// Reset clears the config registers, the load pointer and all valid flags;
// the element memory is not cleared and must be loaded before it is searched.
`default_nettype none
`include "rotated_array_lower_bound_search_macros.svh"

module rotated_array_lower_bound_search #(
  parameter int unsigned MAX_ENTRIES = rals_pkg::MAX_ENTRIES_DEF
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               cfg_we_i,
  input  wire logic                               cfg_index_i,
  input  wire logic [rals_pkg::CFG_W-1:0]         cfg_wdata_i,
  input  wire logic                               in_valid_i,
  output logic                                    in_stall_o,
  input  wire logic                               req_type_i,
  input  wire logic signed [rals_pkg::DATA_W-1:0] value_i,
  output logic                                    out_valid_o,
  input  wire logic                               out_stall_i,
  output logic                                    found_o,
  output logic [rals_pkg::CFG_W-1:0]              position_o
);
  import rals_pkg::*;

  rals_cmd_t       push_cmd, pop_cmd;
  rals_fifo_stat_t fifo_stat;
  logic            push, pop;

  rals_front #(
    .MAX_ENTRIES(MAX_ENTRIES)
  ) u_front (
    .clk_i,
    .rst_ni,
    .cfg_we_i,
    .cfg_index_i,
    .cfg_wdata_i,
    .in_valid_i,
    .in_stall_o,
    .req_type_i,
    .value_i,
    .fifo_stat_i(fifo_stat),
    .push_o     (push),
    .cmd_o      (push_cmd)
  );

  rals_fifo u_fifo (
    .clk_i,
    .rst_ni,
    .push_i(push),
    .cmd_i (push_cmd),
    .pop_i (pop),
    .cmd_o (pop_cmd),
    .stat_o(fifo_stat)
  );

  rals_back #(
    .MAX_ENTRIES(MAX_ENTRIES)
  ) u_back (
    .clk_i,
    .rst_ni,
    .cmd_i      (pop_cmd),
    .cmd_valid_i(!fifo_stat.empty),
    .cmd_pop_o  (pop),
    .out_valid_o,
    .out_stall_i,
    .found_o,
    .position_o
  );

  `RALS_ASSERT(a_miss_pos_zero, out_valid_o && !found_o |-> position_o == '0, "miss with position")
  `RALS_ASSERT_NEVER(a_hit_pos_nonzero, out_valid_o && found_o && position_o == '0, "hit at zero")
  `RALS_ASSERT(a_query_queued, in_valid_i && !in_stall_o && req_type_i |=> !fifo_stat.empty, "query lost")

endmodule

`default_nettype wire

FILE: hdl/rals_front.sv
`default_nettype none

module rals_front #(
  parameter int unsigned MAX_ENTRIES = rals_pkg::MAX_ENTRIES_DEF
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             cfg_we_i,
  input  wire logic                             cfg_index_i,
  input  wire logic [rals_pkg::CFG_W-1:0]       cfg_wdata_i,
  input  wire logic                             in_valid_i,
  output logic                                  in_stall_o,
  input  wire logic                             req_type_i,
  input  wire logic signed [rals_pkg::DATA_W-1:0] value_i,
  input  wire rals_pkg::rals_fifo_stat_t        fifo_stat_i,
  output logic                                  push_o,
  output rals_pkg::rals_cmd_t                   cmd_o
);
  import rals_pkg::*;

  logic [CFG_W-1:0] cnt_q, rot_q, lp_q, lp_d;
  logic [CFG_W-1:0] n, k, pos;
  logic             accept, is_query, load_ok;

  always_comb begin
    n = (32'(cnt_q) < MAX_ENTRIES) ? cnt_q : CFG_W'(MAX_ENTRIES);
    k = (rot_q < n) ? rot_q : n;
    pos = (lp_q >= k) ? lp_q - k : lp_q + n - k;
    in_stall_o = fifo_stat_i.full;
    accept = in_valid_i && !in_stall_o;
    is_query = (req_e'(req_type_i) == REQ_QUERY);
    load_ok = lp_q < n;
    push_o = accept && (is_query || load_ok);
    lp_d = (accept && !is_query && load_ok) ? lp_q + 1'b1 : lp_q;
    cmd_o.is_query = is_query;
    cmd_o.addr = pos;
    cmd_o.value = value_i;
    cmd_o.split = n - k;
    cmd_o.cnt = n;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      rot_q <= '0;
      lp_q  <= '0;
    end else begin
      lp_q <= lp_d;
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          CFG_ENTRY_COUNT:  cnt_q <= cfg_wdata_i;
          CFG_ROTATE_COUNT: rot_q <= cfg_wdata_i;
          default: ;
        endcase
      end
    end
  end

endmodule

`default_nettype wire

FILE: hdl/rals_fifo.sv
`default_nettype none

module rals_fifo (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      push_i,
  input  wire rals_pkg::rals_cmd_t       cmd_i,
  input  wire logic                      pop_i,
  output rals_pkg::rals_cmd_t            cmd_o,
  output rals_pkg::rals_fifo_stat_t      stat_o
);
  import rals_pkg::*;

  rals_cmd_t  ent_q [2];
  logic       wptr_q, rptr_q;
  logic [1:0] cnt_q;

  always_comb begin
    cmd_o = ent_q[rptr_q];
    stat_o.empty = (cnt_q == 2'd0);
    stat_o.full = (cnt_q == 2'd2);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      if (push_i) wptr_q <= ~wptr_q;
      if (pop_i) rptr_q <= ~rptr_q;
      cnt_q <= cnt_q + {1'b0, push_i} - {1'b0, pop_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) ent_q[wptr_q] <= cmd_i;
  end

endmodule

`default_nettype wire

FILE: hdl/rals_back.sv
`default_nettype none

module rals_back #(
  parameter int unsigned MAX_ENTRIES = rals_pkg::MAX_ENTRIES_DEF
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire rals_pkg::rals_cmd_t        cmd_i,
  input  wire logic                       cmd_valid_i,
  output logic                            cmd_pop_o,
  output logic                            out_valid_o,
  input  wire logic                       out_stall_i,
  output logic                            found_o,
  output logic [rals_pkg::CFG_W-1:0]      position_o
);
  import rals_pkg::*;

  localparam int unsigned AW = $clog2(MAX_ENTRIES);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_PROBE = 2'd1;
  localparam logic [1:0] ST_WAIT  = 2'd2;

  logic signed [DATA_W-1:0] mem [MAX_ENTRIES];
  logic signed [DATA_W-1:0] rd_q [2];
  logic signed [DATA_W-1:0] val_q [2];
  logic signed [DATA_W-1:0] target_q;
  logic [CFG_W-1:0]         lo_q [2];
  logic [CFG_W-1:0]         hi_q [2];
  logic [CFG_W-1:0]         mid [2];
  logic [1:0]               fnd_q;
  logic [1:0]               act;
  logic [1:0]               st_q, st_d;
  logic                     out_valid_q, out_valid_d;
  logic                     found_q;
  logic [CFG_W-1:0]         pos_q, pick;
  logic                     out_free, any_act, start, finish, mem_we;

  always_comb begin
    for (int l = 0; l < 2; l++) begin
      act[l] = lo_q[l] < hi_q[l];
      mid[l] = lo_q[l] + ((hi_q[l] - lo_q[l]) >> 1);
    end
    any_act = |act;
    out_free = !out_valid_q || !out_stall_i;
    cmd_pop_o = (st_q == ST_IDLE) && cmd_valid_i;
    mem_we = cmd_pop_o && !cmd_i.is_query;
    start = cmd_pop_o && cmd_i.is_query;
    finish = (st_q == ST_PROBE) && !any_act && out_free;
    priority if (fnd_q[0] && fnd_q[1]) begin
      pick = (val_q[1] < val_q[0]) ? lo_q[1] : lo_q[0];
    end else if (fnd_q[0]) begin
      pick = lo_q[0];
    end else begin
      pick = lo_q[1];
    end
    st_d = st_q;
    unique case (st_q)
      ST_IDLE:  if (start) st_d = ST_PROBE;
      ST_PROBE: begin
        if (any_act) st_d = ST_WAIT;
        else if (out_free) st_d = ST_IDLE;
      end
      ST_WAIT:  st_d = ST_PROBE;
      default:  st_d = ST_IDLE;
    endcase
    if (finish) out_valid_d = 1'b1;
    else if (!out_stall_i) out_valid_d = 1'b0;
    else out_valid_d = out_valid_q;
    out_valid_o = out_valid_q;
    found_o = found_q;
    position_o = pos_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      st_q        <= st_d;
      out_valid_q <= out_valid_d;
    end
  end

  // both segments are bisected side by side, one read port each
  always_ff @(posedge clk_i) begin
    if (start) begin
      lo_q[0]  <= '0;
      hi_q[0]  <= cmd_i.split;
      lo_q[1]  <= cmd_i.split;
      hi_q[1]  <= cmd_i.cnt;
      fnd_q    <= 2'b00;
      target_q <= cmd_i.value;
    end
    if (st_q == ST_WAIT) begin
      for (int l = 0; l < 2; l++) begin
        if (act[l]) begin
          if (rd_q[l] < target_q) begin
            lo_q[l] <= mid[l] + 1'b1;
          end else begin
            hi_q[l]  <= mid[l];
            fnd_q[l] <= 1'b1;
            val_q[l] <= rd_q[l];
          end
        end
      end
    end
    if (finish) begin
      found_q <= |fnd_q;
      pos_q   <= (|fnd_q) ? pick + 1'b1 : '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) mem[AW'(cmd_i.addr)] <= cmd_i.value;
    for (int l = 0; l < 2; l++) begin
      rd_q[l] <= mem[AW'(mid[l])];
    end
  end

endmodule

`default_nettype wire

FILE: tb/rotated_array_lower_bound_search_tb.sv
`timescale 1ns / 100ps

module rotated_array_lower_bound_search_tb;
  import rals_pkg::*;

  localparam int unsigned DEPTH         = MAX_ENTRIES_DEF;
  localparam int unsigned CFG_MAX       = (1 << CFG_W) - 1;
  localparam int unsigned QUIET_LIMIT   = 4000;
  localparam int unsigned SETTLE_CYCLES = 40;
  localparam int unsigned PHASE_WORDS   = 45;
  localparam logic signed [DATA_W-1:0] VAL_MIN = {1'b1, {(DATA_W-1){1'b0}}};
  localparam logic signed [DATA_W-1:0] VAL_MAX = {1'b0, {(DATA_W-1){1'b1}}};

  typedef struct packed {
    logic             found;
    logic [CFG_W-1:0] position;
  } lb_answer_t;

  typedef struct packed {
    req_e                     op;
    logic signed [DATA_W-1:0] value;
  } search_word_t;

  typedef enum logic [1:0] {
    STALL_NONE,
    STALL_SOME,
    STALL_HEAVY
  } stall_mode_e;

  logic                     clk_i = 1'b0;
  logic                     rst_ni;
  logic                     cfg_we_i;
  logic                     cfg_index_i;
  logic [CFG_W-1:0]         cfg_wdata_i;
  logic                     in_valid_i = 1'b0;
  logic                     in_stall_o;
  logic                     req_type_i = REQ_LOAD;
  logic signed [DATA_W-1:0] value_i = '0;
  logic                     out_valid_o;
  logic                     out_stall_i = 1'b0;
  logic                     found_o;
  logic [CFG_W-1:0]         position_o;

  // search model state
  logic signed [DATA_W-1:0] model_mem [DEPTH];
  logic [CFG_W-1:0]         model_ptr;
  logic [CFG_W-1:0]         model_entries;
  logic [CFG_W-1:0]         model_rotate;
  lb_answer_t               expected_answers [$];

  // stimulus side
  logic signed [DATA_W-1:0] content [DEPTH];
  search_word_t             stim_words [$];
  int unsigned              gen_n = 0;
  int unsigned              gen_k = 0;
  int unsigned              gen_ptr = 0;
  int unsigned              wrap_pos;
  int unsigned              words_queued = 0;
  int unsigned              words_accepted = 0;
  int unsigned              idle_cycles = 0;
  int unsigned              err_count = 0;
  bit                       word_taken = 1'b0;
  int unsigned              gap_left = 0;
  int unsigned              burst_left = 0;
  stall_mode_e              stall_mode = STALL_NONE;
  int unsigned              mode_left = 0;

  rotated_array_lower_bound_search #(
    .MAX_ENTRIES(DEPTH)
  ) uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_index_i(cfg_index_i),
    .cfg_wdata_i(cfg_wdata_i),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .req_type_i (req_type_i),
    .value_i    (value_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .found_o    (found_o),
    .position_o (position_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic int unsigned lb_bisect(int unsigned lo, int unsigned hi,
                                            logic signed [DATA_W-1:0] target);
    int unsigned mid;
    while (lo < hi) begin
      mid = lo + (hi - lo) / 2;
      if (mid < DEPTH && model_mem[mid] < target) lo = mid + 1;
      else hi = mid;
    end
    return lo;
  endfunction

  task automatic model_word(logic kind, logic signed [DATA_W-1:0] v);
    int unsigned n, k, split, a, b, pick, slot;
    logic hit_a, hit_b;
    lb_answer_t ans;
    n = (model_entries < DEPTH) ? model_entries : DEPTH;
    k = (model_rotate < n) ? model_rotate : n;
    if (req_e'(kind) == REQ_LOAD) begin
      if (model_ptr < n) begin
        slot = (model_ptr >= k) ? model_ptr - k : model_ptr + n - k;
        model_mem[slot] = v;
        model_ptr = model_ptr + 1'b1;
      end
    end else begin
      split = n - k;
      a = lb_bisect(0, split, v);
      b = lb_bisect(split, n, v);
      hit_a = (a < split);
      hit_b = (b < n);
      if (hit_a && hit_b) pick = (model_mem[b] < model_mem[a]) ? b : a;
      else pick = hit_a ? a : b;
      ans.found = hit_a | hit_b;
      ans.position = ans.found ? CFG_W'(pick + 1) : '0;
      expected_answers.push_back(ans);
    end
  endtask

  always @(posedge clk_i) begin : observe
    bit moved;
    lb_answer_t want;
    if (!rst_ni) begin
      model_ptr = '0;
      model_entries = '0;
      model_rotate = '0;
      idle_cycles = 0;
    end else begin
      moved = 1'b0;
      if (cfg_we_i) begin
        moved = 1'b1;
        if (cfg_index_i == CFG_ENTRY_COUNT) model_entries = cfg_wdata_i;
        else model_rotate = cfg_wdata_i;
      end
      if (in_valid_i && !in_stall_o) begin
        model_word(req_type_i, value_i);
        word_taken = 1'b1;
        words_accepted++;
        moved = 1'b1;
      end
      if (out_valid_o && !out_stall_i) begin
        moved = 1'b1;
        if (expected_answers.size() == 0) begin
          $error("unexpected result word: found %0b position %0d", found_o, position_o);
          err_count++;
        end else begin
          want = expected_answers.pop_front();
          if (found_o !== want.found) begin
            $error("found: expected %0b, actual %0b", want.found, found_o);
            err_count++;
          end
          if (position_o !== want.position) begin
            $error("position: expected %0d, actual %0d", want.position, position_o);
            err_count++;
          end
        end
      end
      idle_cycles = moved ? 0 : idle_cycles + 1;
    end
  end

  // sender: bursts and gaps
  always @(negedge clk_i) begin : feed
    logic nxt_valid;
    search_word_t w;
    nxt_valid = in_valid_i && !word_taken;
    word_taken = 1'b0;
    if (rst_ni && !nxt_valid) begin
      if (gap_left > 0) begin
        gap_left--;
      end else if (stim_words.size() > 0) begin
        w = stim_words.pop_front();
        req_type_i <= w.op;
        value_i <= w.value;
        nxt_valid = 1'b1;
        if (burst_left > 0) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(1, 60);
          gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
        end
      end
    end
    in_valid_i <= nxt_valid;
  end

  // receiver: stall pattern switches mode now and then
  always @(negedge clk_i) begin : sink
    if (mode_left == 0) begin
      stall_mode = stall_mode_e'($urandom_range(0, 2));
      mode_left = $urandom_range(20, 300);
    end else begin
      mode_left--;
    end
    case (stall_mode)
      STALL_NONE: out_stall_i <= 1'b0;
      STALL_SOME: out_stall_i <= ($urandom_range(0, 2) == 0);
      default:    out_stall_i <= ($urandom_range(0, 5) != 0);
    endcase
  end

  initial begin : watchdog
    do @(negedge clk_i);
    while (idle_cycles < QUIET_LIMIT);
    $display("rotated_array_lower_bound_search_tb: errors");
    $finish;
  end

  task automatic wait_drained();
    do @(negedge clk_i);
    while (words_accepted != words_queued || expected_answers.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic program_register(logic idx, logic [CFG_W-1:0] data);
    @(negedge clk_i);
    cfg_we_i = 1'b1;
    cfg_index_i = idx;
    cfg_wdata_i = data;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  task automatic set_regs(int unsigned entries, int unsigned rotate);
    wait_drained();
    program_register(CFG_ENTRY_COUNT, CFG_W'(entries));
    program_register(CFG_ROTATE_COUNT, CFG_W'(rotate));
    gen_n = (entries < DEPTH) ? entries : DEPTH;
    gen_k = (rotate < gen_n) ? rotate : gen_n;
    @(posedge clk_i);
  endtask

  task automatic push_word(req_e op_kind, logic signed [DATA_W-1:0] v);
    stim_words.push_back('{op: op_kind, value: v});
    words_queued++;
  endtask

  // value chosen so the slot it lands in gets its planned content
  task automatic push_load();
    logic signed [DATA_W-1:0] v;
    int unsigned slot;
    v = {$urandom, $urandom};
    if (gen_ptr < gen_n) begin
      slot = (gen_ptr >= gen_k) ? gen_ptr - gen_k : gen_ptr + gen_n - gen_k;
      v = content[slot];
      gen_ptr++;
    end
    push_word(REQ_LOAD, v);
  endtask

  task automatic push_random_word();
    logic signed [DATA_W-1:0] v;
    int unsigned pick;
    pick = $urandom_range(0, 99);
    v = {$urandom, $urandom};
    if (gen_n > 0 && pick < 35) begin
      v = content[$urandom_range(0, gen_n - 1)];
    end else if (gen_n > 0 && pick < 50) begin
      v = content[$urandom_range(0, gen_n - 1)] + ($urandom_range(0, 1) ? 64'sd1 : -64'sd1);
    end else if (pick < 60) begin
      case ($urandom_range(0, 3))
        0:       v = VAL_MIN;
        1:       v = VAL_MAX;
        2:       v = '0;
        default: v = '1;
      endcase
    end
    if (pick >= 88) push_load();
    else push_word(REQ_QUERY, v);
  endtask

  initial begin : stimulus
    logic signed [DATA_W-1:0] ramp [DEPTH];
    logic [63:0] key, step, nxt;
    int unsigned rot, n_pick, k_pick, fill;
    cfg_we_i = 1'b0;
    cfg_index_i = CFG_ENTRY_COUNT;
    cfg_wdata_i = '0;
    rst_ni = 1'b0;

    // ascending values with duplicates, min to max, then rotated
    key = '0;
    for (int j = 0; j < DEPTH; j++) begin
      if (j > 0 && $urandom_range(0, 4) != 0) begin
        step = {$urandom, $urandom} >> $urandom_range(8, 14);
        nxt = key + step;
        key = (nxt < key) ? '1 : nxt;
      end
      if (j == DEPTH - 1) key = '1;
      ramp[j] = key ^ {1'b1, {(DATA_W-1){1'b0}}};
    end
    rot = $urandom_range(100, 900);
    ramp[rot] = ramp[rot - 1];  // equal values on both sides of the wrap
    for (int j = 0; j < DEPTH; j++) content[j] = ramp[(j + rot) % DEPTH];
    wrap_pos = DEPTH - rot;

    repeat (7) @(posedge clk_i);
    @(negedge clk_i) rst_ni = 1'b1;
    @(posedge clk_i);

    // empty array
    push_word(REQ_QUERY, VAL_MIN);
    push_word(REQ_QUERY, VAL_MAX);
    push_load();

    // small rotated fill
    set_regs(8, 3);
    repeat (8) push_load();
    push_word(REQ_QUERY, VAL_MIN);
    push_word(REQ_QUERY, content[0]);
    push_word(REQ_QUERY, content[4]);
    push_word(REQ_QUERY, content[5]);
    push_word(REQ_QUERY, content[7]);
    push_word(REQ_QUERY, content[7] + 64'sd1);
    push_word(REQ_QUERY, VAL_MAX);
    push_load();

    set_regs(8, CFG_MAX);
    push_word(REQ_QUERY, content[3]);
    push_word(REQ_QUERY, content[0]);
    set_regs(8, 0);
    push_word(REQ_QUERY, content[6]);
    push_word(REQ_QUERY, VAL_MIN);

    // fill the rest of the store
    set_regs(CFG_MAX, 0);
    fill = DEPTH - gen_ptr + 3;
    repeat (fill) push_load();

    for (int ph = 0; ph < 10; ph++) begin
      case (ph)
        0: begin n_pick = DEPTH; k_pick = rot; end
        1: begin n_pick = DEPTH; k_pick = 0; end
        2: begin n_pick = CFG_MAX; k_pick = CFG_MAX; end
        3: begin n_pick = 1; k_pick = 0; end
        4: begin n_pick = 2; k_pick = 1; end
        5: begin n_pick = 0; k_pick = $urandom_range(0, CFG_MAX); end
        default: begin
          n_pick = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 16)
                                                : $urandom_range(wrap_pos + 1, DEPTH);
          case ($urandom_range(0, 2))
            0:       k_pick = (n_pick > wrap_pos) ? n_pick - wrap_pos : 0;
            1:       k_pick = $urandom_range(0, n_pick);
            default: k_pick = $urandom_range(0, CFG_MAX);
          endcase
        end
      endcase
      set_regs(n_pick, k_pick);
      repeat (PHASE_WORDS) push_random_word();
    end

    wait_drained();
    if (err_count == 0) begin
      $display("rotated_array_lower_bound_search_tb: clean");
    end else begin
      $display("rotated_array_lower_bound_search_tb: errors");
    end
    $finish;
  end

endmodule
